// ===== src/sepf_pkg.sv =====
// Shared types and constants for the secure element packet framer.
// Used by sepf_front, sepf_queue, sepf_back and the top level; no dependencies.
`default_nettype none

package sepf_pkg;

  // Input actions carried on in_tuser
  localparam logic [1:0] ACT_HDR   = 2'd0;
  localparam logic [1:0] ACT_EXTRA = 2'd1;
  localparam logic [1:0] ACT_RESP  = 2'd2;

  // Result kinds carried on out_tuser
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_RDATA   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [1:0] VERD_OK      = 2'd0;
  localparam logic [1:0] VERD_BAD_LEN = 2'd1;
  localparam logic [1:0] VERD_BAD_CRC = 2'd2;
  localparam logic [1:0] VERD_SEQ     = 2'd3;

  localparam logic [7:0] WORD_ADDR = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int unsigned FWD_LIMIT = 32;

  typedef enum logic [1:0] {
    J_HDR,
    J_XB,
    J_DATA,
    J_VERD
  } job_kind_t;

  // One classified job handed from front to back
  typedef struct packed {
    job_kind_t   jkind;
    logic [7:0]  byte_a;    // opcode, extra byte or response data byte
    logic [7:0]  byte_b;    // param1
    logic [7:0]  cnt;       // command count byte
    logic [15:0] crc;       // crc to append
    logic        add_crc;   // append crc low and high bytes
    logic [1:0]  verdict;
    logic [7:0]  status;
    logic [5:0]  dlen;
  } job_t;

endpackage

`default_nettype wire

// ===== src/sepf_front.sv =====
// Front end: accepts input items, tracks command/response phase, runs the CRC.
// Pushes classified jobs into the queue; depends on sepf_pkg.
`default_nettype none

module sepf_front #(
  parameter int unsigned MAX_EXTRA    = 32,
  parameter int unsigned MAX_RESP_LEN = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_tuser,
  input  wire logic [31:0]   in_tdata,
  input  wire logic          q_full,
  output logic               q_push,
  output sepf_pkg::job_t     q_job
);

  typedef enum logic [1:0] {F_RUN, F_OP, F_P1} fstate_t;
  typedef enum logic [1:0] {PH_IDLE, PH_EXTRA, PH_RESP} phase_t;

  fstate_t     fst_r, fst_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [5:0]  extra_left_r, extra_left_nxt;
  logic [5:0]  elen_r, elen_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  p1_r, p1_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  logic [7:0]  f_op, f_p1, f_b;
  logic [5:0]  f_elen, elen_sat;
  logic [7:0]  cnt_new;
  logic        accept;
  logic [15:0] feed_acc, feed_out;
  logic [7:0]  feed_byte;
  logic [7:0]  idx_p2;

  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] v;
    v = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ sepf_pkg::CRC_POLY) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

  assign f_op   = in_tdata[7:0];
  assign f_p1   = in_tdata[15:8];
  assign f_elen = in_tdata[21:16];
  assign f_b    = in_tdata[29:22];

  assign in_tready = (fst_r == F_RUN) && !q_full;
  assign accept    = in_tvalid && in_tready;

  assign elen_sat = ({1'b0, f_elen} > 7'(MAX_EXTRA)) ? 6'(MAX_EXTRA) : f_elen;
  assign cnt_new  = {2'b00, elen_sat} + 8'd5;
  assign idx_p2   = {1'b0, idx_r} + 8'd2;

  // Select what the single CRC byte unit consumes this cycle
  always_comb begin
    feed_acc  = crc_r;
    feed_byte = f_b;
    unique case (fst_r)
      F_OP: feed_byte = op_r;
      F_P1: feed_byte = p1_r;
      default: begin
        if (in_tuser == sepf_pkg::ACT_HDR) begin
          feed_acc  = 16'h0000;
          feed_byte = cnt_new;
        end else if (in_tuser == sepf_pkg::ACT_RESP && phase_r == PH_IDLE) begin
          feed_acc = 16'h0000;
        end
      end
    endcase
  end

  assign feed_out = crc_feed(feed_acc, feed_byte);

  always_comb begin
    fst_nxt        = fst_r;
    phase_nxt      = phase_r;
    crc_nxt        = crc_r;
    extra_left_nxt = extra_left_r;
    elen_nxt       = elen_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    status_nxt     = status_r;
    crc_lo_nxt     = crc_lo_r;
    op_nxt         = op_r;
    p1_nxt         = p1_r;
    cnt_nxt        = cnt_r;
    q_push         = 1'b0;
    q_job          = '0;
    q_job.jkind    = sepf_pkg::J_VERD;

    unique case (fst_r)
      F_OP: begin
        crc_nxt = feed_out;
        fst_nxt = F_P1;
      end
      F_P1: begin
        if (!q_full) begin
          q_push        = 1'b1;
          q_job.jkind   = sepf_pkg::J_HDR;
          q_job.byte_a  = op_r;
          q_job.byte_b  = p1_r;
          q_job.cnt     = cnt_r;
          q_job.crc     = feed_out;
          q_job.add_crc = (elen_r == 6'd0);
          crc_nxt       = feed_out;
          extra_left_nxt = elen_r;
          phase_nxt     = (elen_r == 6'd0) ? PH_IDLE : PH_EXTRA;
          fst_nxt       = F_RUN;
        end
      end
      default: begin
        if (accept) begin
          priority case (in_tuser)
            sepf_pkg::ACT_HDR: begin
              if (phase_r != PH_IDLE) begin
                phase_nxt     = PH_IDLE;
                q_push        = 1'b1;
                q_job.verdict = sepf_pkg::VERD_SEQ;
              end else begin
                crc_nxt  = feed_out;
                op_nxt   = f_op;
                p1_nxt   = f_p1;
                cnt_nxt  = cnt_new;
                elen_nxt = elen_sat;
                fst_nxt  = F_OP;
              end
            end
            sepf_pkg::ACT_EXTRA: begin
              q_push = 1'b1;
              if (phase_r != PH_EXTRA || extra_left_r == 6'd0) begin
                phase_nxt     = PH_IDLE;
                q_job.verdict = sepf_pkg::VERD_SEQ;
              end else begin
                crc_nxt        = feed_out;
                q_job.jkind    = sepf_pkg::J_XB;
                q_job.byte_a   = f_b;
                q_job.crc      = feed_out;
                q_job.add_crc  = (extra_left_r == 6'd1);
                extra_left_nxt = extra_left_r - 6'd1;
                if (extra_left_r == 6'd1) begin
                  phase_nxt = PH_IDLE;
                end
              end
            end
            sepf_pkg::ACT_RESP: begin
              if (phase_r == PH_EXTRA) begin
                phase_nxt     = PH_IDLE;
                q_push        = 1'b1;
                q_job.verdict = sepf_pkg::VERD_SEQ;
              end else if (phase_r != PH_RESP) begin
                if (f_b < 8'd4 || f_b > 8'(MAX_RESP_LEN)) begin
                  phase_nxt     = PH_IDLE;
                  q_push        = 1'b1;
                  q_job.verdict = sepf_pkg::VERD_BAD_LEN;
                end else begin
                  crc_nxt   = feed_out;
                  len_nxt   = f_b[6:0];
                  idx_nxt   = 7'd1;
                  phase_nxt = PH_RESP;
                end
              end else if (idx_p2 < {1'b0, len_r}) begin
                crc_nxt = feed_out;
                if (idx_r == 7'd1) begin
                  status_nxt = f_b;
                end
                if ((idx_r - 7'd1) < 7'(sepf_pkg::FWD_LIMIT)) begin
                  q_push       = 1'b1;
                  q_job.jkind  = sepf_pkg::J_DATA;
                  q_job.byte_a = f_b;
                end
                idx_nxt = idx_r + 7'd1;
              end else if (idx_p2 == {1'b0, len_r}) begin
                crc_lo_nxt = f_b;
                idx_nxt    = idx_r + 7'd1;
              end else begin
                q_push        = 1'b1;
                q_job.verdict = ({f_b, crc_lo_r} == crc_r) ? sepf_pkg::VERD_OK
                                                          : sepf_pkg::VERD_BAD_CRC;
                q_job.status  = status_r;
                q_job.dlen    = 6'(len_r - 7'd3);
                phase_nxt     = PH_IDLE;
              end
            end
            default: begin
              // unused action: drop silently
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r        <= F_RUN;
      phase_r      <= PH_IDLE;
      extra_left_r <= '0;
    end else begin
      fst_r        <= fst_nxt;
      phase_r      <= phase_nxt;
      extra_left_r <= extra_left_nxt;
    end
    crc_r    <= crc_nxt;
    elen_r   <= elen_nxt;
    idx_r    <= idx_nxt;
    len_r    <= len_nxt;
    status_r <= status_nxt;
    crc_lo_r <= crc_lo_nxt;
    op_r     <= op_nxt;
    p1_r     <= p1_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

`default_nettype wire

// ===== src/sepf_queue.sv =====
// Short job queue between front and back of the packet framer.
// Register-based FIFO of sepf_pkg::job_t entries.
`default_nettype none

module sepf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  sepf_pkg::job_t      push_job,
  input  wire logic           pop,
  output sepf_pkg::job_t      head_job,
  output logic                empty,
  output logic                full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sepf_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign head_job = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== src/sepf_back.sv =====
// Back end: expands each queued job into result items, one per cycle unless out_tready stalls.
// Drives the registered result channel; depends on sepf_pkg.
`default_nettype none

module sepf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  sepf_pkg::job_t      head_job,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [1:0]          out_tuser,
  output logic [23:0]         out_tdata,
  output logic                out_tlast
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] obyte;
    logic [1:0] verdict;
    logic [7:0] status;
    logic [5:0] dlen;
    logic       last;
  } res_t;

  logic [2:0] step_r, step_nxt;
  logic [2:0] nres;
  logic       valid_r, valid_nxt;
  res_t       res_r, res_nxt, item;
  logic       load;

  // Result count and the item at the current step
  always_comb begin
    item = '0;
    nres = 3'd1;
    unique case (head_job.jkind)
      sepf_pkg::J_HDR: begin
        nres      = head_job.add_crc ? 3'd6 : 3'd4;
        item.kind = sepf_pkg::KIND_TX;
        unique case (step_r)
          3'd0:    item.obyte = sepf_pkg::WORD_ADDR;
          3'd1:    item.obyte = head_job.cnt;
          3'd2:    item.obyte = head_job.byte_a;
          3'd3:    item.obyte = head_job.byte_b;
          3'd4:    item.obyte = head_job.crc[7:0];
          default: item.obyte = head_job.crc[15:8];
        endcase
      end
      sepf_pkg::J_XB: begin
        nres      = head_job.add_crc ? 3'd3 : 3'd1;
        item.kind = sepf_pkg::KIND_TX;
        unique case (step_r)
          3'd0:    item.obyte = head_job.byte_a;
          3'd1:    item.obyte = head_job.crc[7:0];
          default: item.obyte = head_job.crc[15:8];
        endcase
      end
      sepf_pkg::J_DATA: begin
        item.kind  = sepf_pkg::KIND_RDATA;
        item.obyte = head_job.byte_a;
      end
      default: begin
        item.kind    = sepf_pkg::KIND_VERDICT;
        item.verdict = head_job.verdict;
        item.status  = head_job.status;
        item.dlen    = head_job.dlen;
      end
    endcase
    item.last = (step_r == nres - 3'd1);
  end

  assign load  = !q_empty && (!valid_r || out_tready);
  assign q_pop = load && item.last;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      res_nxt   = item;
      valid_nxt = 1'b1;
      step_nxt  = item.last ? 3'd0 : step_r + 3'd1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {res_r.dlen, res_r.status, res_r.verdict, res_r.obyte};

endmodule

`default_nettype wire

// ===== src/secure_element_packet_framer.sv =====
// Top level of the secure element packet framer: front end, job queue, back end.
// Depends on sepf_pkg, sepf_front, sepf_queue and sepf_back.
`default_nettype none

// Frames commands for a secure element byte link and checks its responses.
// A header item (in_tuser 0) produces the word address 0x03, the count
// (extra length plus 5, extra length capped at MAX_EXTRA), the opcode and
// param1; each extra byte item (in_tuser 1) is sent on, and after the last
// one the CRC16 (poly 0x1021, init 0, MSB first, over count..extra bytes) is
// sent low byte first. Response byte items (in_tuser 2) start with a count
// in 4..MAX_RESP_LEN; status and data bytes (up to 32) are forwarded and the
// final CRC byte yields a verdict item carrying the status byte and the
// response length minus three. Out-of-order items produce an out-of-sequence
// verdict and return the block to idle; in_tuser 3 is dropped.
// Rate: extra and response byte items are taken one per cycle while the
// job queue has room; after a header item the input waits while the single
// CRC byte unit in the front end folds in count, opcode and param1 one per
// cycle. The back end emits one result item per cycle unless out_tready
// stalls it; a header gives four or six items and sets the command rate.
// out_tlast marks the final result caused by one input item.
module secure_element_packet_framer #(
  parameter int unsigned MAX_EXTRA    = 32,
  parameter int unsigned MAX_RESP_LEN = 64,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // action
  input  wire logic [31:0] in_tdata,   // opcode[7:0], param1[15:8], extra_len[21:16],
                                       // data_byte[29:22], zero[31:30]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // kind
  output logic [23:0]      out_tdata,  // out_byte[7:0], verdict[9:8],
                                       // device_status[17:10], data_len[23:18]
  output logic             out_tlast   // last
);

  logic           q_push, q_pop, q_empty, q_full;
  sepf_pkg::job_t push_job, head_job;

  // Classify input items and run the CRC
  sepf_front #(
    .MAX_EXTRA    (MAX_EXTRA),
    .MAX_RESP_LEN (MAX_RESP_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Decouple front and back so either can stall
  sepf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Expand jobs into result items
  sepf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // Hold a stalled result item unchanged until the receiver takes it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tuser) &&
                                     $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result item changed");

  // A verdict is always the final result of its item
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == sepf_pkg::KIND_VERDICT) |-> out_tlast)
    else $error("verdict without last");

endmodule

`default_nettype wire
